// ===== rtl/assert_macros.svh =====
// assertion macros for the checker file
// expects signals named clock and reset in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define MI3_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("matrix inverse check failed");

// next-cycle implication, held off during reset
`define MI3_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("matrix inverse check failed");

// same-cycle implication, also checked through reset
`define MI3_ASSERT_RAW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error("matrix inverse check failed");

`endif

// ===== rtl/mi3_pkg.sv =====
// shared types, widths and constants of the 3x3 matrix inverse unit
// no dependencies
package mi3_pkg;

   localparam int Lanes      = 9;
   localparam int DataW      = 32;
   localparam int ProdW      = 2 * DataW;
   localparam int MinorW     = ProdW + 1;
   localparam int AdjAbsW    = ProdW;
   localparam int PartW      = DataW + 33;
   localparam int DetW       = 97;
   localparam int AbsW       = DetW - 1;
   localparam int LimitW     = 63;
   localparam int QuotW      = DataW + 1;
   localparam int FrontDepth = 7;
   localparam int LaneDepth  = QuotW + 1;
   localparam int TotalDepth = FrontDepth + LaneDepth;
   localparam int TdataW     = Lanes * DataW;

   localparam logic [LimitW-1:0] SingularLimitReset = 63'd281474977;
   localparam logic [DataW-1:0]  PosSat = 32'h7fff_ffff;
   localparam logic [DataW-1:0]  NegSat = 32'h8000_0000;
   localparam logic [QuotW-1:0]  NegLimit = 33'h0_8000_0000;
   localparam logic [QuotW-1:0]  PosLimit = 33'h0_7fff_ffff;
   localparam logic [TdataW-1:0] IdentityTdata =
      {32'h0001_0000, 96'h0, 32'h0001_0000, 96'h0, 32'h0001_0000};

   // cofactor operands per adjugate entry: adj = m[a]*m[d] - m[b]*m[c]
   localparam int MinorA [Lanes] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int MinorD [Lanes] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int MinorB [Lanes] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int MinorC [Lanes] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

   typedef logic signed [DataW-1:0] data_type;
   typedef data_type mat_type [Lanes];

   typedef struct packed {
      logic [Lanes-1:0][AdjAbsW-1:0] adj_abs;
      logic [Lanes-1:0]              adj_neg;
      logic [AbsW-1:0]               det_abs;
      logic                          det_neg;
      logic                          singular;
   } front_type;

endpackage

// ===== rtl/mi3_front.sv =====
// minors, adjugate and exact determinant of one matrix, seven register stages
// depends on mi3_pkg
module mi3_front (
   input  logic                         clock,
   input  logic                         adv,
   input  mi3_pkg::mat_type             m_in,
   input  logic [mi3_pkg::LimitW-1:0]   limit,
   output mi3_pkg::front_type           front_out
);
   import mi3_pkg::*;

   data_type                   m_ff   [Lanes];
   logic signed [ProdW-1:0]    pa_ff  [Lanes];
   logic signed [ProdW-1:0]    pb_ff  [Lanes];
   data_type                   r0a_ff [3];
   data_type                   r0b_ff [3];
   logic signed [MinorW-1:0]   adj_ff [4][Lanes];
   logic signed [PartW-1:0]    lo_ff  [3];
   logic signed [PartW-1:0]    hi_ff  [3];
   logic signed [DetW-1:0]     term_ff [3];
   logic signed [DetW-1:0]     det_ff;
   front_type                  out_ff;
   logic [DetW-1:0]            det_mag;

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff <= m_in;
         for (int k = 0; k < Lanes; k++) begin
            pa_ff[k]     <= m_ff[MinorA[k]] * m_ff[MinorD[k]];
            pb_ff[k]     <= m_ff[MinorB[k]] * m_ff[MinorC[k]];
            adj_ff[0][k] <= MinorW'(pa_ff[k]) - MinorW'(pb_ff[k]);
            adj_ff[1][k] <= adj_ff[0][k];
            adj_ff[2][k] <= adj_ff[1][k];
            adj_ff[3][k] <= adj_ff[2][k];
         end
         for (int c = 0; c < 3; c++) begin
            r0a_ff[c]  <= m_ff[c];
            r0b_ff[c]  <= r0a_ff[c];
            // row 0 entry times adjugate column 0 entry, split in halves
            lo_ff[c]   <= r0b_ff[c] * $signed({1'b0, adj_ff[0][c*3][DataW-1:0]});
            hi_ff[c]   <= r0b_ff[c] * $signed(adj_ff[0][c*3][MinorW-1:DataW]);
            term_ff[c] <= (DetW'(hi_ff[c]) <<< DataW) + DetW'(lo_ff[c]);
         end
         det_ff <= term_ff[0] + term_ff[1] + term_ff[2];
         out_ff.det_abs  <= det_mag[AbsW-1:0];
         out_ff.det_neg  <= det_ff[DetW-1];
         out_ff.singular <= (det_mag == '0) ||
                            (det_mag[AbsW-1:0] < {{(AbsW-LimitW){1'b0}}, limit});
         for (int k = 0; k < Lanes; k++) begin
            out_ff.adj_abs[k] <= adj_ff[3][k][MinorW-1] ?
                                 AdjAbsW'(-adj_ff[3][k]) : AdjAbsW'(adj_ff[3][k]);
            out_ff.adj_neg[k] <= adj_ff[3][k][MinorW-1];
         end
      end
   end

   assign det_mag   = det_ff[DetW-1] ? DetW'(-det_ff) : DetW'(det_ff);
   assign front_out = out_ff;

endmodule

// ===== rtl/mi3_lane.sv =====
// one divider lane: (|adj| << 32) / |det|, one quotient bit per stage, saturated
// depends on mi3_pkg
module mi3_lane (
   input  logic                          clock,
   input  logic                          adv,
   input  logic [mi3_pkg::AdjAbsW-1:0]   adj_abs,
   input  logic                          adj_neg,
   input  logic [mi3_pkg::AbsW-1:0]      det_abs,
   input  logic                          det_neg,
   output logic [mi3_pkg::DataW-1:0]     quot
);
   import mi3_pkg::*;

   logic [AbsW-1:0]  rem_ff [LaneDepth];
   logic [AbsW-1:0]  div_ff [LaneDepth];
   logic [QuotW-1:0] q_ff   [LaneDepth];
   logic [QuotW-1:0] nlo_ff [LaneDepth];
   logic             neg_ff [LaneDepth];
   logic             ovf_ff [LaneDepth];
   logic [AbsW:0]    shifted [QuotW];
   logic             ge      [QuotW];
   logic [AbsW:0]    diff    [QuotW];
   logic [QuotW-1:0] q_last;
   logic [QuotW-1:0] negq;

   always_comb begin
      for (int j = 0; j < QuotW; j++) begin
         shifted[j] = {rem_ff[j], nlo_ff[j][QuotW-1]};
         ge[j]      = shifted[j] >= {1'b0, div_ff[j]};
         diff[j]    = shifted[j] - {1'b0, div_ff[j]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // quotient would need more than 33 bits: saturate later
         rem_ff[0] <= {{(AbsW-AdjAbsW+1){1'b0}}, adj_abs[AdjAbsW-1:1]};
         ovf_ff[0] <= {{(AbsW-AdjAbsW+1){1'b0}}, adj_abs[AdjAbsW-1:1]} >= det_abs;
         nlo_ff[0] <= {adj_abs[0], {(QuotW-1){1'b0}}};
         q_ff[0]   <= '0;
         div_ff[0] <= det_abs;
         neg_ff[0] <= adj_neg ^ det_neg;
         for (int j = 0; j < QuotW; j++) begin
            rem_ff[j+1] <= ge[j] ? diff[j][AbsW-1:0] : shifted[j][AbsW-1:0];
            q_ff[j+1]   <= {q_ff[j][QuotW-2:0], ge[j]};
            nlo_ff[j+1] <= {nlo_ff[j][QuotW-2:0], 1'b0};
            div_ff[j+1] <= div_ff[j];
            neg_ff[j+1] <= neg_ff[j];
            ovf_ff[j+1] <= ovf_ff[j];
         end
      end
   end

   assign q_last = q_ff[LaneDepth-1];
   assign negq   = '0 - q_last;

   always_comb begin
      if (!neg_ff[LaneDepth-1]) begin
         quot = (ovf_ff[LaneDepth-1] || q_last > PosLimit) ? PosSat : q_last[DataW-1:0];
      end else begin
         quot = (ovf_ff[LaneDepth-1] || q_last > NegLimit) ? NegSat : negq[DataW-1:0];
      end
   end

endmodule

// ===== rtl/matrix3x3_inverse_unit.sv =====
// top level of the 3x3 matrix inverse unit: handshake, limit register, lanes, merge
// depends on mi3_pkg, mi3_front and mi3_lane
//
// One request carries a 3x3 matrix of signed Q16.16 entries; one response carries its
// inverse in signed Q16.16, rounded toward zero and saturated, with tuser set when the
// determinant magnitude is below the limit register (csr_wdata as last written, else
// its reset value; units of 2^-48; always when the determinant is zero), in which case
// the identity is returned instead. The unit takes a new request every cycle unless
// the pipeline halts, and holds no state between requests but the limit register.
// A result passes through the seven-stage minor/determinant front end, then nine
// 34-stage divider lanes, one quotient bit per stage, then the response register.
// The pipeline only halts when its last stage and the response register are both
// full and the response is not being taken.
module matrix3x3_inverse_unit (
   input  logic                          clock,
   input  logic                          reset,
   // request: m00 m01 m02 m10 m11 m12 m20 m21 m22 from bit 0 up, 32 bits each
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [mi3_pkg::TdataW-1:0]    req_tdata,
   // response: inv00 inv01 inv02 inv10 inv11 inv12 inv20 inv21 inv22 from bit 0 up
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mi3_pkg::TdataW-1:0]    rsp_tdata,
   // response flag: singular
   output logic                          rsp_tuser,
   // singular limit register
   input  logic                          csr_we,
   input  logic [mi3_pkg::LimitW-1:0]    csr_wdata
);
   import mi3_pkg::*;

   logic                    adv;
   logic [TotalDepth-1:0]   vld_ff, vld_in;
   logic [LaneDepth-1:0]    sing_ff;
   logic [LimitW-1:0]       limit_ff, limit_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [TdataW-1:0]       rsp_data_ff;
   logic                    rsp_sing_ff;
   mat_type                 m_in;
   front_type               front_out;
   logic [Lanes-1:0][DataW-1:0] lane_quot;

   // pipeline moves unless the last stage is blocked by a waiting response
   assign adv        = !vld_ff[TotalDepth-1] || !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   always_comb begin
      for (int k = 0; k < Lanes; k++) begin
         m_in[k] = req_tdata[k*DataW +: DataW];
      end
   end

   mi3_front u_front (
      .clock     (clock),
      .adv       (adv),
      .m_in      (m_in),
      .limit     (limit_ff),
      .front_out (front_out)
   );

   for (genvar k = 0; k < Lanes; k++) begin : g_lane
      mi3_lane u_lane (
         .clock   (clock),
         .adv     (adv),
         .adj_abs (front_out.adj_abs[k]),
         .adj_neg (front_out.adj_neg[k]),
         .det_abs (front_out.det_abs),
         .det_neg (front_out.det_neg),
         .quot    (lane_quot[k])
      );
   end

   always_comb begin
      vld_in       = adv ? {vld_ff[TotalDepth-2:0], req_tvalid} : vld_ff;
      limit_in     = csr_we ? csr_wdata : limit_ff;
      rsp_valid_in = rsp_valid_ff;
      if (adv && vld_ff[TotalDepth-1]) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= SingularLimitReset;
      end else begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
         limit_ff     <= limit_in;
      end
   end

   // singular flag rides alongside the divider lanes
   always_ff @(posedge clock) begin
      if (adv) begin
         sing_ff <= {sing_ff[LaneDepth-2:0], front_out.singular};
      end
      // merge the lanes, or substitute the identity
      if (adv && vld_ff[TotalDepth-1]) begin
         rsp_data_ff <= sing_ff[LaneDepth-1] ? IdentityTdata : lane_quot;
         rsp_sing_ff <= sing_ff[LaneDepth-1];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sing_ff;

endmodule

// ===== rtl/mi3_checker.sv =====
// port-level checks of the matrix inverse unit, bound to the top level
// depends on mi3_pkg and assert_macros.svh
`include "assert_macros.svh"

module mi3_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [mi3_pkg::TdataW-1:0] rsp_tdata,
   input logic                       rsp_tuser
);
   import mi3_pkg::*;

   `MI3_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `MI3_ASSERT_NEXT(a_rsp_stable, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tuser))
   `MI3_ASSERT_NOW(a_identity, rsp_tvalid && rsp_tuser, rsp_tdata == IdentityTdata)
   `MI3_ASSERT_NOW(a_stall_cause, !req_tready, rsp_tvalid && !rsp_tready)
   `MI3_ASSERT_RAW(a_reset_clears, $past(reset), !rsp_tvalid)

endmodule

bind matrix3x3_inverse_unit mi3_checker u_mi3_checker (.*);
